// ===== design/vtd_pkg.sv =====
package vtd_pkg;

    localparam int XW = 35;          // vectoring x/y width
    localparam int ZW = 32;          // binary angle width, one turn wraps
    localparam int CW = 33;          // rotation x/y width, q2.30 with headroom
    localparam int AW = 34;          // rotation residual angle width
    localparam int VW = 28;          // velocity width, units of 2^-16
    localparam int ATAN_COUNT = 24;
    localparam int QDEPTH = 4;
    localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;

    // configuration register indexes
    localparam logic REG_SPEED_GAIN = 1'b0;
    localparam logic REG_TURN_GAIN  = 1'b1;

    typedef struct packed {
        logic [VW-1:0]        vel;
        logic signed [ZW-1:0] ang;
        logic                 neg;
        logic                 wide;
    } t_mid;

    function automatic logic [ZW-1:0] atan_val(input int idx);
        logic [ZW-1:0] v;
        case (idx)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== design/vtd_front.sv =====
module vtd_front #(
    parameter int NS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  logic               i_valid,
    input  logic signed [15:0] i_dir_x,
    input  logic signed [15:0] i_dir_y,
    input  logic signed [15:0] i_heading,
    input  logic [15:0]        i_speed_gain,
    output logic               o_valid,
    output vtd_pkg::t_mid      o_word
);

    localparam logic signed [31:0] HALF_PI = 32'sh4000_0000;
    localparam logic signed [31:0] NEG_HALF_PI = 32'shC000_0000;
    localparam logic [29:0] INV_GAIN = vtd_pkg::INV_GAIN_Q30;

    logic                         r_v [0:NS];
    logic signed [vtd_pkg::XW-1:0] r_x [0:NS];
    logic signed [vtd_pkg::XW-1:0] r_y [0:NS];
    logic [vtd_pkg::ZW-1:0]       r_z [0:NS];
    logic [15:0]                  r_hd [0:NS];

    logic signed [vtd_pkg::XW-1:0] x_in;
    logic signed [vtd_pkg::XW-1:0] y_in;
    assign x_in = {{3{i_dir_x[15]}}, i_dir_x, 16'd0};
    assign y_in = {{3{i_dir_y[15]}}, i_dir_y, 16'd0};

    // negative x: turn the vector by pi first
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            if (i_dir_x[15]) begin
                r_x[0] <= -x_in;
                r_y[0] <= -y_in;
                r_z[0] <= 32'h8000_0000;
            end else begin
                r_x[0] <= x_in;
                r_y[0] <= y_in;
                r_z[0] <= '0;
            end
            r_hd[0] <= i_heading;
        end
    end

    genvar k;
    generate
        for (k = 0; k < NS; k++) begin : g_vec
            localparam logic [vtd_pkg::ZW-1:0] AT = vtd_pkg::atan_val(k);
            always_ff @(posedge i_clk) begin
                if (i_adv) begin
                    if (r_y[k][vtd_pkg::XW-1]) begin
                        r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                        r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                        r_z[k+1] <= r_z[k] - AT;
                    end else begin
                        r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                        r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                        r_z[k+1] <= r_z[k] + AT;
                    end
                    r_hd[k+1] <= r_hd[k];
                end
            end
        end
    endgenerate

    // angle difference, folded into [-pi/2, pi/2]
    logic signed [31:0] d;
    logic               d_wide;
    logic               d_neg;
    logic signed [31:0] d_fold;
    always_comb begin
        d      = $signed(r_z[NS] - {r_hd[NS], 16'd0});
        d_wide = (d >= HALF_PI) || (d <= NEG_HALF_PI);
        d_neg  = (d > HALF_PI) || (d < NEG_HALF_PI);
        d_fold = d_neg ? {~d[31], d[30:0]} : d;
    end

    // magnitude times 1/K, split into two partial products (x is non-negative)
    logic [32:0] xm;
    assign xm = r_x[NS][32:0];

    logic               r_va, r_vb, r_vc;
    logic [46:0]        r_plo;
    logic [45:0]        r_phi;
    logic signed [31:0] r_ang_a, r_ang_b, r_ang_c;
    logic               r_neg_a, r_neg_b, r_neg_c;
    logic               r_wide_a, r_wide_b, r_wide_c;
    logic [31:0]        r_mag;
    logic [vtd_pkg::VW-1:0] r_vel;

    logic [63:0] mag_sum;
    logic [47:0] vel_prod;
    assign mag_sum  = {1'b0, r_phi, 17'd0} + {17'd0, r_plo};
    assign vel_prod = r_mag * i_speed_gain;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_plo    <= xm[16:0] * INV_GAIN;
            r_phi    <= xm[32:17] * INV_GAIN;
            r_ang_a  <= d_fold;
            r_neg_a  <= d_neg;
            r_wide_a <= d_wide;
            r_mag    <= mag_sum[61:30];
            r_ang_b  <= r_ang_a;
            r_neg_b  <= r_neg_a;
            r_wide_b <= r_wide_a;
            r_vel    <= vel_prod[47:20];
            r_ang_c  <= r_ang_b;
            r_neg_c  <= r_neg_b;
            r_wide_c <= r_wide_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= NS; j++) r_v[j] <= 1'b0;
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else if (i_adv) begin
            r_v[0] <= i_valid;
            for (int j = 0; j < NS; j++) r_v[j+1] <= r_v[j];
            r_va <= r_v[NS];
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    assign o_valid     = r_vc;
    assign o_word.vel  = r_vel;
    assign o_word.ang  = r_ang_c;
    assign o_word.neg  = r_neg_c;
    assign o_word.wide = r_wide_c;

    // after the pi pre-turn the vector lies in the right half plane
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[0] |-> !r_x[0][vtd_pkg::XW-1])
        else $error("vectoring start has negative x");
    // a folded angle never exceeds a quarter turn
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_va |-> (r_ang_a <= HALF_PI) && (r_ang_a >= NEG_HALF_PI))
        else $error("angle fold out of range");
    // a folded angle is always counted as wide
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_va && r_neg_a |-> r_wide_a)
        else $error("fold without wide flag");

endmodule

// ===== design/vtd_queue.sv =====
module vtd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  vtd_pkg::t_mid i_word,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output vtd_pkg::t_mid o_word
);

    localparam int PW = $clog2(vtd_pkg::QDEPTH);

    vtd_pkg::t_mid r_mem [0:vtd_pkg::QDEPTH-1];
    logic [PW-1:0] r_wr, r_rd;
    logic [PW:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            if (i_push && !i_pop)      r_count <= r_count + 1'b1;
            else if (!i_push && i_pop) r_count <= r_count - 1'b1;
        end
    end

    assign o_full  = (r_count == (PW+1)'(vtd_pkg::QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_word  = r_mem[r_rd];

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (PW+1)'(vtd_pkg::QDEPTH))
        else $error("queue count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("write into full queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("read from empty queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count lost a word");

endmodule

// ===== design/vtd_back.sv =====
module vtd_back #(
    parameter int NS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  logic               i_valid,
    input  vtd_pkg::t_mid      i_word,
    input  logic [15:0]        i_turn_gain,
    output logic               o_valid,
    output logic signed [15:0] o_left,
    output logic signed [15:0] o_right,
    output logic               o_clip
);

    localparam logic signed [vtd_pkg::CW-1:0] CX0 =
        vtd_pkg::CW'(vtd_pkg::INV_GAIN_Q30);

    logic                          r_v   [0:NS];
    logic signed [vtd_pkg::CW-1:0] r_cx  [0:NS];
    logic signed [vtd_pkg::CW-1:0] r_cy  [0:NS];
    logic signed [vtd_pkg::AW-1:0] r_a   [0:NS];
    logic [vtd_pkg::VW-1:0]        r_vel [0:NS];
    logic                          r_neg [0:NS];
    logic                          r_wide [0:NS];

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_cx[0]   <= CX0;
            r_cy[0]   <= '0;
            r_a[0]    <= {{2{i_word.ang[31]}}, i_word.ang};
            r_vel[0]  <= i_word.vel;
            r_neg[0]  <= i_word.neg;
            r_wide[0] <= i_word.wide;
        end
    end

    genvar k;
    generate
        for (k = 0; k < NS; k++) begin : g_rot
            localparam logic signed [vtd_pkg::AW-1:0] AT =
                $signed({2'b00, vtd_pkg::atan_val(k)});
            always_ff @(posedge i_clk) begin
                if (i_adv) begin
                    if (!r_a[k][vtd_pkg::AW-1]) begin
                        r_cx[k+1] <= r_cx[k] - (r_cy[k] >>> k);
                        r_cy[k+1] <= r_cy[k] + (r_cx[k] >>> k);
                        r_a[k+1]  <= r_a[k] - AT;
                    end else begin
                        r_cx[k+1] <= r_cx[k] + (r_cy[k] >>> k);
                        r_cy[k+1] <= r_cy[k] - (r_cx[k] >>> k);
                        r_a[k+1]  <= r_a[k] + AT;
                    end
                    r_vel[k+1]  <= r_vel[k];
                    r_neg[k+1]  <= r_neg[k];
                    r_wide[k+1] <= r_wide[k];
                end
            end
        end
    endgenerate

    logic signed [vtd_pkg::CW-1:0] cxn, cyn;
    logic signed [vtd_pkg::VW:0]   vel_s;
    assign cxn   = r_neg[NS] ? -r_cx[NS] : r_cx[NS];
    assign cyn   = r_neg[NS] ? -r_cy[NS] : r_cy[NS];
    assign vel_s = $signed({1'b0, r_vel[NS]});

    logic               r_vp, r_vq;
    logic signed [61:0] r_pf, r_ps;
    logic               r_wide_p, r_wide_q;
    logic signed [31:0] r_fwd;
    logic signed [48:0] r_pt;

    logic signed [31:0] sn;
    assign sn = 32'(r_ps >>> 30);

    // turn term, wheel sums, round to q3.12, saturate
    logic signed [40:0] turn;
    logic signed [41:0] sum_l, sum_r;
    logic signed [37:0] rnd_l, rnd_r;
    logic signed [15:0] sat_l, sat_r;
    logic               clip_l, clip_r;
    always_comb begin
        turn = 41'(r_pt >>> 8);
        if (r_wide_q) begin
            sum_l = 42'(r_fwd) + 42'(turn);
            sum_r = 42'(r_fwd) - 42'(turn);
        end else begin
            sum_l = 42'(r_fwd) - 42'(turn);
            sum_r = 42'(r_fwd) + 42'(turn);
        end
        rnd_l = 38'((sum_l + 42'sd8) >>> 4);
        rnd_r = 38'((sum_r + 42'sd8) >>> 4);
        clip_l = 1'b1;
        clip_r = 1'b1;
        if (rnd_l > 38'sd32767)       sat_l = 16'sh7FFF;
        else if (rnd_l < -38'sd32768) sat_l = 16'sh8000;
        else begin
            sat_l  = rnd_l[15:0];
            clip_l = 1'b0;
        end
        if (rnd_r > 38'sd32767)       sat_r = 16'sh7FFF;
        else if (rnd_r < -38'sd32768) sat_r = 16'sh8000;
        else begin
            sat_r  = rnd_r[15:0];
            clip_r = 1'b0;
        end
    end

    logic signed [15:0] r_left, r_right;
    logic               r_clip, r_vo;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_pf     <= 62'(vel_s) * 62'(cxn);
            r_ps     <= 62'(vel_s) * 62'(cyn);
            r_wide_p <= r_wide[NS];
            r_fwd    <= 32'(r_pf >>> 30);
            r_pt     <= 49'(sn) * 49'($signed({1'b0, i_turn_gain}));
            r_wide_q <= r_wide_p;
            r_left   <= sat_l;
            r_right  <= sat_r;
            r_clip   <= clip_l | clip_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= NS; j++) r_v[j] <= 1'b0;
            r_vp <= 1'b0;
            r_vq <= 1'b0;
            r_vo <= 1'b0;
        end else if (i_adv) begin
            r_v[0] <= i_valid;
            for (int j = 0; j < NS; j++) r_v[j+1] <= r_v[j];
            r_vp <= r_v[NS];
            r_vq <= r_vp;
            r_vo <= r_vq;
        end
    end

    assign o_valid = r_vo;
    assign o_left  = r_left;
    assign o_right = r_right;
    assign o_clip  = r_clip;

    // a shown result holds while the output is stalled
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vo && !i_adv |=> r_vo && $stable(r_left) && $stable(r_right))
        else $error("result changed while stalled");
    // rotation always starts from the positive x axis
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[0] |-> r_cx[0] == CX0 && r_cy[0] == '0)
        else $error("rotation start vector wrong");
    // a clipped result has at least one wheel on a rail
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vo && r_clip |-> r_left == 16'sh7FFF || r_left == 16'sh8000
                           || r_right == 16'sh7FFF || r_right == 16'sh8000)
        else $error("clip flag inconsistent");

endmodule

// ===== design/vector_to_differential_wheel_speed.sv =====
// Differential-drive wheel speeds from a direction vector and the robot heading.
// One word is taken per clock and one result leaves per clock while pop keeps up.
// A word passes a vectoring CORDIC pipeline (min(CORDIC_STAGES,24) stages plus
// four for the pi pre-turn, 1/K scaling, speed gain and angle fold), a four-word
// queue, then a rotation CORDIC pipeline of as many stages plus four for the load,
// products, rounding and saturation; a word waits in the queue behind any words
// that it already holds. Gains are written through i_cfg_*: index 0 speed gain,
// index 1 turn gain, both unsigned q8.8, reset to 1.0.
module vector_to_differential_wheel_speed #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [15:0] i_dir_x,
    input  logic signed [15:0] i_dir_y,
    input  logic signed [15:0] i_heading,
    output logic               empty,
    input  logic               pop,
    output logic signed [15:0] o_left_speed,
    output logic signed [15:0] o_right_speed,
    output logic               o_clipped,
    input  logic               i_cfg_we,
    input  logic               i_cfg_addr,
    input  logic [15:0]        i_cfg_wdata
);

    localparam int NS = (CORDIC_STAGES > vtd_pkg::ATAN_COUNT) ?
                        vtd_pkg::ATAN_COUNT : CORDIC_STAGES;

    logic [15:0] r_speed_gain, r_turn_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_gain <= 16'd256;
            r_turn_gain  <= 16'd256;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                vtd_pkg::REG_SPEED_GAIN: r_speed_gain <= i_cfg_wdata;
                vtd_pkg::REG_TURN_GAIN:  r_turn_gain  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    logic          f_valid, f_adv;
    vtd_pkg::t_mid f_word, q_word;
    logic          q_full, q_empty, q_push, q_pop;
    logic          b_valid, b_adv;

    assign f_adv  = !f_valid || !q_full;
    assign full   = !f_adv;
    assign q_push = f_valid && !q_full;

    vtd_front #(.NS(NS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (f_adv),
        .i_valid      (push && f_adv),
        .i_dir_x      (i_dir_x),
        .i_dir_y      (i_dir_y),
        .i_heading    (i_heading),
        .i_speed_gain (r_speed_gain),
        .o_valid      (f_valid),
        .o_word       (f_word)
    );

    vtd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_word  (f_word),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_word  (q_word)
    );

    assign b_adv = !b_valid || pop;
    assign q_pop = !q_empty && b_adv;
    assign empty = !b_valid;

    vtd_back #(.NS(NS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (b_adv),
        .i_valid     (q_pop),
        .i_word      (q_word),
        .i_turn_gain (r_turn_gain),
        .o_valid     (b_valid),
        .o_left      (o_left_speed),
        .o_right     (o_right_speed),
        .o_clip      (o_clipped)
    );

endmodule
